// ===== src/lgct_pkg.sv =====
// ----------------------------------------------------------------------------
// lgct_pkg
// shared constants, codes and beat types of the chunk transmitter
// ----------------------------------------------------------------------------
package lgct_pkg;

	localparam int NumSamples = 32;
	localparam int IdxW       = $clog2(NumSamples);
	localparam int CntW       = $clog2(NumSamples + 1);
	localparam int StoreW     = 32;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	localparam logic [7:0] RssiThresholdRst = 8'hBA;
	localparam logic [7:0] RequiredRunRst   = 8'd3;
	localparam logic [5:0] SampleCountRst   = 6'd20;

	typedef enum logic [1:0] {
		FuncSample = 2'd0,
		FuncBeacon = 2'd1,
		FuncAck    = 2'd2,
		FuncTimer  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KindBeacon  = 2'd0,
		KindRequest = 2'd1,
		KindData    = 2'd2,
		KindDone    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CfgRssiThreshold = 2'd0,
		CfgRequiredRun   = 2'd1,
		CfgSampleCount   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic        vld;
		kind_t       kind;
		logic [4:0]  seq;
		logic        link;
		logic        last;
	} desc_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  chunk_seq;
		logic [15:0] light_value;
		logic [15:0] motion_value;
		logic        link_up;
		logic        last;
	} beat_t;

	typedef struct packed {
		logic  a_vld;
		logic  b_vld;
		beat_t a;
		beat_t b;
	} push_t;

endpackage

// ===== src/lgct_ram.sv =====
// ----------------------------------------------------------------------------
// lgct_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lgct_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/lgct_front.sv =====
// ----------------------------------------------------------------------------
// lgct_front
// accepts events, updates link and transfer state, writes and reads the sample store
// and hands up to two result beats per event to the queue
// ----------------------------------------------------------------------------
module lgct_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [7:0]              cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              func,
	input  logic signed [15:0]      light_sample,
	input  logic signed [15:0]      motion_sample,
	input  logic signed [7:0]       rssi,
	input  logic [7:0]              ack_seq,
	input  logic [lgct_pkg::QCntW-1:0] q_cnt,
	output lgct_pkg::push_t         push
);

	logic [7:0] thr_q;
	logic [7:0] run_q;
	logic [5:0] scount_q;

	logic                      link_q, link_n;
	logic [7:0]                good_q, good_n;
	logic [7:0]                bad_q, bad_n;
	logic [lgct_pkg::CntW-1:0] fill_q, fill_n;
	logic                      full_q, full_n;
	logic                      active_q, active_n;
	logic [lgct_pkg::IdxW-1:0] chunk_q, chunk_n;

	lgct_pkg::desc_t desc_a_s1, desc_b_s1, desc_a_n, desc_b_n;

	logic                      acc;
	logic [lgct_pkg::CntW-1:0] count;
	logic [7:0]                need;
	logic [lgct_pkg::CntW-1:0] fill_inc;
	logic [lgct_pkg::CntW-1:0] chunk_inc;
	logic                      good_rx;
	logic                      ram_we, ram_re;
	logic [lgct_pkg::IdxW-1:0] ram_waddr, ram_raddr;
	logic [lgct_pkg::StoreW-1:0] ram_rdata;
	logic [lgct_pkg::QCntW:0]  slots;
	logic                      rd_zero_n, rd_zero_s1;

	lgct_ram #(
		.Width(lgct_pkg::StoreW),
		.Depth(lgct_pkg::NumSamples)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({light_sample, motion_sample}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// room for everything in flight plus two beats of this event
	assign slots = {1'b0, q_cnt} + (lgct_pkg::QCntW+1)'(desc_a_s1.vld)
		+ (lgct_pkg::QCntW+1)'(desc_b_s1.vld) + (lgct_pkg::QCntW+1)'(2);
	assign in_stall = slots > (lgct_pkg::QCntW+1)'(lgct_pkg::QDepth);
	assign acc = in_valid && !in_stall;

	always_comb begin
		if (scount_q == 6'd0) begin
			count = lgct_pkg::CntW'(1);
		end else if ({3'b0, scount_q} > 9'(lgct_pkg::NumSamples)) begin
			count = lgct_pkg::CntW'(lgct_pkg::NumSamples);
		end else begin
			count = lgct_pkg::CntW'(scount_q);
		end
	end

	assign need      = (run_q == 8'd0) ? 8'd1 : run_q;
	assign fill_inc  = fill_q + lgct_pkg::CntW'(1);
	assign chunk_inc = lgct_pkg::CntW'(chunk_q) + lgct_pkg::CntW'(1);
	assign good_rx   = $signed(rssi) >= $signed(thr_q);
	assign ram_waddr = fill_q[lgct_pkg::IdxW-1:0];
	// entries at or past the fill level hold nothing of this round
	assign rd_zero_n = lgct_pkg::CntW'(ram_raddr) >= fill_q;

	always_comb begin
		link_n    = link_q;
		good_n    = good_q;
		bad_n     = bad_q;
		fill_n    = fill_q;
		full_n    = full_q;
		active_n  = active_q;
		chunk_n   = chunk_q;
		desc_a_n  = '0;
		desc_b_n  = '0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (acc) begin
			case (func)
				lgct_pkg::FuncSample: begin
					if (!full_q) begin
						if (fill_q >= count) begin
							full_n = 1'b1;
						end else begin
							ram_we = 1'b1;
							fill_n = fill_inc;
							if (fill_inc >= count) begin
								full_n = 1'b1;
							end
						end
					end
				end
				lgct_pkg::FuncBeacon: begin
					if (good_rx) begin
						good_n = (good_q == 8'hFF) ? good_q : good_q + 8'd1;
						bad_n  = 8'd0;
					end else begin
						bad_n  = (bad_q == 8'hFF) ? bad_q : bad_q + 8'd1;
						good_n = 8'd0;
					end
					if (!link_q && good_n >= need) begin
						link_n = 1'b1;
					end
					if (link_n && bad_n >= need) begin
						link_n = 1'b0;
					end
					if (full_q && link_n && !active_q) begin
						active_n       = 1'b1;
						chunk_n        = '0;
						ram_re         = 1'b1;
						ram_raddr      = '0;
						desc_a_n.vld   = 1'b1;
						desc_a_n.kind  = lgct_pkg::KindRequest;
						desc_a_n.link  = link_n;
						desc_b_n.vld   = 1'b1;
						desc_b_n.kind  = lgct_pkg::KindData;
						desc_b_n.link  = link_n;
						desc_b_n.last  = 1'b1;
					end
				end
				lgct_pkg::FuncAck: begin
					if (active_q && ack_seq == 8'(chunk_q)) begin
						desc_a_n.vld  = 1'b1;
						desc_a_n.last = 1'b1;
						if (chunk_inc >= count) begin
							fill_n        = '0;
							full_n        = 1'b0;
							active_n      = 1'b0;
							chunk_n       = '0;
							good_n        = 8'd0;
							bad_n         = 8'd0;
							link_n        = 1'b0;
							desc_a_n.kind = lgct_pkg::KindDone;
							desc_a_n.link = 1'b0;
						end else begin
							chunk_n       = chunk_inc[lgct_pkg::IdxW-1:0];
							ram_re        = 1'b1;
							ram_raddr     = chunk_inc[lgct_pkg::IdxW-1:0];
							desc_a_n.kind = lgct_pkg::KindData;
							desc_a_n.seq  = 5'(chunk_inc);
							desc_a_n.link = link_q;
						end
					end
				end
				lgct_pkg::FuncTimer: begin
					if (!active_q) begin
						desc_a_n.vld  = 1'b1;
						desc_a_n.kind = lgct_pkg::KindBeacon;
						desc_a_n.link = link_q;
						desc_a_n.last = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= lgct_pkg::RssiThresholdRst;
			run_q    <= lgct_pkg::RequiredRunRst;
			scount_q <= lgct_pkg::SampleCountRst;
		end else if (cfg_we) begin
			case (cfg_index)
				lgct_pkg::CfgRssiThreshold: thr_q    <= cfg_data;
				lgct_pkg::CfgRequiredRun:   run_q    <= cfg_data;
				lgct_pkg::CfgSampleCount:   scount_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q     <= 1'b0;
			good_q     <= 8'd0;
			bad_q      <= 8'd0;
			fill_q     <= '0;
			full_q     <= 1'b0;
			active_q   <= 1'b0;
			chunk_q    <= '0;
			desc_a_s1  <= '0;
			desc_b_s1  <= '0;
			rd_zero_s1 <= 1'b0;
		end else begin
			link_q     <= link_n;
			good_q     <= good_n;
			bad_q      <= bad_n;
			fill_q     <= fill_n;
			full_q     <= full_n;
			active_q   <= active_n;
			chunk_q    <= chunk_n;
			desc_a_s1  <= desc_a_n;
			desc_b_s1  <= desc_b_n;
			rd_zero_s1 <= rd_zero_n;
		end
	end

	// data beats pick up the store word read in the accepting cycle
	always_comb begin
		push.a_vld          = desc_a_s1.vld;
		push.b_vld          = desc_b_s1.vld;
		push.a.kind         = desc_a_s1.kind;
		push.a.chunk_seq    = desc_a_s1.seq;
		push.a.link_up      = desc_a_s1.link;
		push.a.last         = desc_a_s1.last;
		push.a.light_value  = '0;
		push.a.motion_value = '0;
		push.b.kind         = desc_b_s1.kind;
		push.b.chunk_seq    = desc_b_s1.seq;
		push.b.link_up      = desc_b_s1.link;
		push.b.last         = desc_b_s1.last;
		push.b.light_value  = '0;
		push.b.motion_value = '0;
		if (desc_a_s1.kind == lgct_pkg::KindData && !rd_zero_s1) begin
			push.a.light_value  = ram_rdata[31:16];
			push.a.motion_value = ram_rdata[15:0];
		end
		if (desc_b_s1.kind == lgct_pkg::KindData && !rd_zero_s1) begin
			push.b.light_value  = ram_rdata[31:16];
			push.b.motion_value = ram_rdata[15:0];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) active_q |-> full_q)
		else $error("transfer running without a full store");
	assert property (@(posedge clk) disable iff (!arst_n) desc_b_s1.vld |-> desc_a_s1.vld)
		else $error("second beat without a first");
	assert property (@(posedge clk) disable iff (!arst_n) !acc |=> $stable(link_q))
		else $error("link state moved without an event");

endmodule

// ===== src/lgct_queue.sv =====
// ----------------------------------------------------------------------------
// lgct_queue
// result queue: takes up to two beats per cycle and, when not stalled, delivers one
// ----------------------------------------------------------------------------
module lgct_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lgct_pkg::push_t            push,
	output logic [lgct_pkg::QCntW-1:0] cnt,
	output logic                       out_valid,
	input  logic                       out_stall,
	output lgct_pkg::beat_t            head
);

	lgct_pkg::beat_t            entries_q [lgct_pkg::QDepth];
	logic [lgct_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [lgct_pkg::QCntW-1:0] cnt_q;
	logic [lgct_pkg::QCntW-1:0] push_n;
	logic                       pop;

	assign push_n    = lgct_pkg::QCntW'(push.a_vld) + lgct_pkg::QCntW'(push.b_vld);
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && !out_stall;
	assign head      = entries_q[rd_ptr_q];
	assign cnt       = cnt_q;

	always_ff @(posedge clk) begin
		if (push.a_vld) begin
			entries_q[wr_ptr_q] <= push.a;
		end
		if (push.b_vld) begin
			entries_q[wr_ptr_q + lgct_pkg::QPtrW'(1)] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + lgct_pkg::QPtrW'(push_n);
			rd_ptr_q <= rd_ptr_q + lgct_pkg::QPtrW'(pop);
			cnt_q    <= cnt_q + push_n - lgct_pkg::QCntW'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} + {1'b0, push_n}) <= (lgct_pkg::QCntW+1)'(lgct_pkg::QDepth))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) push.b_vld |-> push.a_vld)
		else $error("queue push out of order");

endmodule

// ===== src/link_gated_chunk_transmitter.sv =====
// ----------------------------------------------------------------------------
// link_gated_chunk_transmitter
// flow: an accepted event is registered in the front stage, its beats are then
//   written to the result queue and offered from its head in order
// throughput: one event per cycle while the four-entry result queue has room
//   for in-flight beats and two more; results leave at one beat per cycle unless stalled
// reset: asynchronous, clears link state, counters, transfer state and queue;
//   sample store contents stay undefined until written
// ----------------------------------------------------------------------------
module link_gated_chunk_transmitter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [15:0] light_sample,
	input  logic signed [15:0] motion_sample,
	input  logic signed [7:0]  rssi,
	input  logic [7:0]         ack_seq,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         pkt_kind,
	output logic [4:0]         chunk_seq,
	output logic signed [15:0] light_value,
	output logic signed [15:0] motion_value,
	output logic               link_up,
	output logic               last
);

	lgct_pkg::push_t            push;
	lgct_pkg::beat_t            head;
	logic [lgct_pkg::QCntW-1:0] q_cnt;

	lgct_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.light_sample  (light_sample),
		.motion_sample (motion_sample),
		.rssi          (rssi),
		.ack_seq       (ack_seq),
		.q_cnt         (q_cnt),
		.push          (push)
	);

	lgct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.cnt       (q_cnt),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign pkt_kind     = head.kind;
	assign chunk_seq    = head.chunk_seq;
	assign light_value  = head.light_value;
	assign motion_value = head.motion_value;
	assign link_up      = head.link_up;
	assign last         = head.last;

endmodule

// ===== dv/link_gated_chunk_transmitter_tb.sv =====
// ----------------------------------------------------------------------------
// link_gated_chunk_transmitter testbench
// drives sample, beacon, ack and timer events into the transmitter, keeps a
// cycle-free model of the link, sample store and transfer state, and checks
// every result beat in order against the packets that model predicts
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lgct_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [7:0]         cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         func;
	logic signed [15:0] light_sample;
	logic signed [15:0] motion_sample;
	logic signed [7:0]  rssi;
	logic [7:0]         ack_seq;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         pkt_kind;
	logic [4:0]         chunk_seq;
	logic signed [15:0] light_value;
	logic signed [15:0] motion_value;
	logic               link_up;
	logic               last;

	link_gated_chunk_transmitter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.light_sample (light_sample),
		.motion_sample(motion_sample),
		.rssi         (rssi),
		.ack_seq      (ack_seq),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pkt_kind     (pkt_kind),
		.chunk_seq    (chunk_seq),
		.light_value  (light_value),
		.motion_value (motion_value),
		.link_up      (link_up),
		.last         (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// model of the transmitter state
	logic signed [7:0] thr_q;
	logic [7:0]        run_q;
	logic [5:0]        count_q;
	bit                link_q;
	bit [7:0]          good_q;
	bit [7:0]          bad_q;
	int                fill_q;
	bit                full_q;
	bit                xfer_q;
	int                chunk_q;
	logic [15:0]       light_mem [NumSamples];
	logic [15:0]       motion_mem [NumSamples];

	beat_t pending_pkts[$];
	beat_t exp_pkt;
	int    n_errors = 0;

	bit tx_gaps_on = 1'b1;
	bit rx_gaps_on = 1'b1;
	int rx_wait = 0;
	int rx_hold_req = 0;
	int rx_hold_left = 0;

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %0s", $realtime, msg);
		n_errors++;
	endtask

	function automatic int eff_count(input logic [5:0] c);
		if (c == 6'd0)
			return 1;
		if (c > NumSamples)
			return NumSamples;
		return int'(c);
	endfunction

	task automatic push_pkt(input kind_t k, input int seq, input logic [15:0] lv,
			input logic [15:0] mv, input bit lastf);
		beat_t b;
		b.kind         = k;
		b.chunk_seq    = 5'(seq);
		b.light_value  = lv;
		b.motion_value = mv;
		b.link_up      = link_q;
		b.last         = lastf;
		pending_pkts.push_back(b);
	endtask

	task automatic predict_packets(input func_t f, input logic [15:0] lsamp,
			input logic [15:0] msamp, input logic [7:0] r, input logic [7:0] ack);
		int cnt;
		int need;
		cnt  = eff_count(count_q);
		need = (run_q == 8'd0) ? 1 : int'(run_q);
		case (f)
			FuncSample: begin
				if (!full_q) begin
					if (fill_q >= cnt) begin
						full_q = 1'b1;
					end else begin
						light_mem[fill_q]  = lsamp;
						motion_mem[fill_q] = msamp;
						fill_q++;
						if (fill_q >= cnt)
							full_q = 1'b1;
					end
				end
			end
			FuncBeacon: begin
				if ($signed(r) >= thr_q) begin
					if (good_q != 8'd255)
						good_q++;
					bad_q = 8'd0;
				end else begin
					if (bad_q != 8'd255)
						bad_q++;
					good_q = 8'd0;
				end
				if (!link_q && good_q >= need)
					link_q = 1'b1;
				if (link_q && bad_q >= need)
					link_q = 1'b0;
				if (full_q && link_q && !xfer_q) begin
					xfer_q  = 1'b1;
					chunk_q = 0;
					push_pkt(KindRequest, 0, 16'd0, 16'd0, 1'b0);
					push_pkt(KindData, 0, light_mem[0], motion_mem[0], 1'b1);
				end
			end
			FuncAck: begin
				if (xfer_q && int'(ack) == chunk_q) begin
					chunk_q++;
					if (chunk_q >= cnt) begin
						foreach (light_mem[i]) begin
							light_mem[i]  = 16'd0;
							motion_mem[i] = 16'd0;
						end
						fill_q  = 0;
						full_q  = 1'b0;
						xfer_q  = 1'b0;
						chunk_q = 0;
						good_q  = 8'd0;
						bad_q   = 8'd0;
						link_q  = 1'b0;
						push_pkt(KindDone, 0, 16'd0, 16'd0, 1'b1);
					end else begin
						push_pkt(KindData, chunk_q, light_mem[chunk_q], motion_mem[chunk_q], 1'b1);
					end
				end
			end
			default: begin
				if (!xfer_q)
					push_pkt(KindBeacon, 0, 16'd0, 16'd0, 1'b1);
			end
		endcase
	endtask

	// result side: check each beat, then pick how long to stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_pkts.size() == 0) begin
					report_error($sformatf("unexpected beat, kind %0d", pkt_kind));
				end else begin
					exp_pkt = pending_pkts.pop_front();
					if (pkt_kind !== exp_pkt.kind)
						report_error($sformatf("pkt_kind: expected %0d, got %0d",
							exp_pkt.kind, pkt_kind));
					if (chunk_seq !== exp_pkt.chunk_seq)
						report_error($sformatf("chunk_seq: expected %0d, got %0d",
							exp_pkt.chunk_seq, chunk_seq));
					if (light_value !== exp_pkt.light_value)
						report_error($sformatf("light_value: expected %h, got %h",
							exp_pkt.light_value, light_value));
					if (motion_value !== exp_pkt.motion_value)
						report_error($sformatf("motion_value: expected %h, got %h",
							exp_pkt.motion_value, motion_value));
					if (link_up !== exp_pkt.link_up)
						report_error($sformatf("link_up: expected %0d, got %0d",
							exp_pkt.link_up, link_up));
					if (last !== exp_pkt.last)
						report_error($sformatf("last: expected %0d, got %0d",
							exp_pkt.last, last));
				end
				rx_wait = rx_gaps_on ? $urandom_range(0, 9) : 0;
			end
			if (rx_hold_req > 0) begin
				rx_hold_left = rx_hold_req;
				rx_hold_req  = 0;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_event(input func_t f, input logic [15:0] lsamp,
			input logic [15:0] msamp, input logic [7:0] r, input logic [7:0] ack);
		int gap;
		gap = tx_gaps_on ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		func          <= f;
		light_sample  <= lsamp;
		motion_sample <= msamp;
		rssi          <= r;
		ack_seq       <= ack;
		do
			@(posedge clk);
		while (in_stall);
		predict_packets(f, lsamp, msamp, r, ack);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_pkts.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] thr, input logic [7:0] run,
			input logic [7:0] cnt);
		cfg_we    <= 1'b1;
		cfg_index <= CfgRssiThreshold;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_index <= CfgRequiredRun;
		cfg_data  <= run;
		@(posedge clk);
		cfg_index <= CfgSampleCount;
		cfg_data  <= cnt;
		@(posedge clk);
		cfg_we  <= 1'b0;
		thr_q   = thr;
		run_q   = run;
		count_q = cnt[5:0];
	endtask

	task automatic test_directed_events();
		// reset register values
		send_event(FuncTimer, 16'h0000, 16'h0000, 8'd0, 8'd0);
		send_event(FuncAck, 16'h0000, 16'h0000, 8'd0, 8'd0);
		send_event(FuncBeacon, 16'h0000, 16'h0000, -8'sd71, 8'd0);
		send_event(FuncBeacon, 16'h0000, 16'h0000, -8'sd70, 8'd0);
		send_event(FuncBeacon, 16'h0000, 16'h0000, 8'sd127, 8'd0);
		send_event(FuncBeacon, 16'h0000, 16'h0000, 8'sd127, 8'd0);
		send_event(FuncTimer, 16'h0000, 16'h0000, 8'd0, 8'd0);
		wait_drained();
		// zero run acts as one, sample extremes, drop while full
		set_config(8'h7F, 8'h00, 8'd2);
		send_event(FuncSample, 16'h8000, 16'h7FFF, 8'd0, 8'd0);
		send_event(FuncSample, 16'h7FFF, 16'h8000, 8'd0, 8'd0);
		send_event(FuncSample, 16'h0000, 16'h0000, 8'd0, 8'd0);
		send_event(FuncBeacon, 16'h0000, 16'h0000, 8'sd127, 8'd0);
		send_event(FuncTimer, 16'h0000, 16'h0000, 8'd0, 8'd0);
		send_event(FuncAck, 16'h0000, 16'h0000, 8'd0, 8'd255);
		send_event(FuncAck, 16'h0000, 16'h0000, 8'd0, 8'd0);
		send_event(FuncAck, 16'h0000, 16'h0000, 8'd0, 8'd1);
		wait_drained();
		// zero sample count acts as one, lowest threshold
		set_config(8'h80, 8'h00, 8'hC0);
		send_event(FuncSample, 16'hFFFF, 16'h0001, 8'd0, 8'd0);
		send_event(FuncBeacon, 16'h0000, 16'h0000, 8'h80, 8'd0);
		send_event(FuncAck, 16'h0000, 16'h0000, 8'd0, 8'd0);
		wait_drained();
		// count lowered below the fill level
		set_config(8'h00, 8'h01, 8'd63);
		send_event(FuncSample, 16'($urandom), 16'($urandom), 8'd0, 8'd0);
		send_event(FuncSample, 16'($urandom), 16'($urandom), 8'd0, 8'd0);
		send_event(FuncSample, 16'($urandom), 16'($urandom), 8'd0, 8'd0);
		wait_drained();
		set_config(8'h00, 8'h01, 8'd2);
		send_event(FuncSample, 16'($urandom), 16'($urandom), 8'd0, 8'd0);
		send_event(FuncBeacon, 16'h0000, 16'h0000, 8'd0, 8'd0);
		send_event(FuncAck, 16'h0000, 16'h0000, 8'd0, 8'd0);
		send_event(FuncAck, 16'h0000, 16'h0000, 8'd0, 8'd1);
		wait_drained();
	endtask

	task automatic test_backpressure();
		tx_gaps_on  = 1'b0;
		rx_hold_req = 80;
		repeat (24)
			send_event(FuncTimer, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
		wait_drained();
		tx_gaps_on = 1'b1;
	endtask

	task automatic random_event();
		int          pick;
		int          lo;
		func_t       f;
		logic [7:0]  r;
		logic [7:0]  ack;
		pick = $urandom_range(0, 99);
		r    = 8'($urandom);
		ack  = 8'($urandom);
		lo   = int'(thr_q);
		if (xfer_q) begin
			if (pick < 70) begin
				f   = FuncAck;
				ack = 8'(chunk_q);
			end else if (pick < 75) begin
				f   = FuncAck;
				ack = 8'(chunk_q + 32);
			end else if (pick < 85) begin
				f = FuncAck;
			end else begin
				f = func_t'($urandom_range(0, 3));
			end
		end else if (!full_q) begin
			if (pick < 55)
				f = FuncSample;
			else if (pick < 85)
				f = FuncBeacon;
			else
				f = func_t'($urandom_range(0, 3));
		end else begin
			if (pick < 70) begin
				f = FuncBeacon;
				if (pick < 55)
					r = 8'(int'($urandom_range(lo + 128, 255)) - 128);
			end else begin
				f = func_t'($urandom_range(0, 3));
			end
		end
		send_event(f, 16'($urandom), 16'($urandom), r, ack);
	endtask

	task automatic test_random_traffic();
		int         sent;
		int         n;
		int         sel;
		logic [7:0] thr;
		logic [7:0] run;
		logic [7:0] cnt;
		sent = 0;
		while (sent < 1500) begin
			wait_drained();
			sel = $urandom_range(0, 7);
			thr = (sel == 0) ? 8'h80 : (sel == 1) ? 8'h7F : 8'($urandom);
			sel = $urandom_range(0, 9);
			run = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : (sel == 2) ? 8'($urandom) :
				8'($urandom_range(1, 4));
			sel = $urandom_range(0, 9);
			cnt[5:0] = (sel == 0) ? 6'd0 : (sel == 1) ? 6'd32 : (sel == 2) ? 6'd63 :
				(sel == 3) ? 6'($urandom) : 6'($urandom_range(1, 8));
			cnt[7:6] = 2'($urandom);
			// a held store must never grow past its written entries
			if ((full_q || xfer_q) && eff_count(cnt[5:0]) > eff_count(count_q))
				cnt[5:0] = count_q;
			set_config(thr, run, cnt);
			tx_gaps_on = ($urandom_range(0, 3) != 0);
			rx_gaps_on = ($urandom_range(0, 3) != 0);
			n = $urandom_range(40, 120);
			repeat (n) random_event();
			sent += n;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CfgRssiThreshold;
		cfg_data      = 8'd0;
		in_valid      = 1'b0;
		func          = FuncSample;
		light_sample  = 16'd0;
		motion_sample = 16'd0;
		rssi          = 8'd0;
		ack_seq       = 8'd0;
		out_stall     = 1'b0;
		thr_q         = RssiThresholdRst;
		run_q         = RequiredRunRst;
		count_q       = SampleCountRst;
		link_q        = 1'b0;
		good_q        = 8'd0;
		bad_q         = 8'd0;
		fill_q        = 0;
		full_q        = 1'b0;
		xfer_q        = 1'b0;
		chunk_q       = 0;
		foreach (light_mem[i]) begin
			light_mem[i]  = 16'd0;
			motion_mem[i] = 16'd0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_events();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		if (n_errors == 0)
			$display("link_gated_chunk_transmitter test passed");
		else
			$display("link_gated_chunk_transmitter test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("link_gated_chunk_transmitter test failed");
		$finish;
	end

endmodule
